### rtl/core/vprl_pkg.sv
// Shared types and constants of the velocity profile rate limiter.
`timescale 1ns / 1ps

package vprl_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int LIMIT_W   = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEED_FLOOR   = 3'd0,
		CFG_SPEED_CEILING = 3'd1,
		CFG_TURN_LIMIT    = 3'd2,
		CFG_STEP_DELTA_V  = 3'd3,
		CFG_STEP_DELTA_W  = 3'd4
	} cfg_reg_t;

	localparam int                 CEILING_RST    = 1024;
	localparam logic [LIMIT_W-1:0] TURN_LIMIT_RST = 15'd1024;
	localparam logic [LIMIT_W-1:0] STEP_DELTA_RST = 15'd51;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WALK,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic in_ready;
		logic walk;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_last;
		logic walking;
		logic out_free;
	} ctrl_status_t;

endpackage

### rtl/core/vprl_if.sv
// Stream interfaces for horizon steps in and velocity commands out.
`timescale 1ns / 1ps

interface vprl_step_if #(parameter int VALUE_WIDTH = 16) ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] ref_linear;
	logic signed [VALUE_WIDTH-1:0] ref_angular;
	logic                          last_step;

	modport source(output valid, ref_linear, ref_angular, last_step, input ready);
	modport sink(input valid, ref_linear, ref_angular, last_step, output ready);
endinterface

interface vprl_cmd_if #(parameter int VALUE_WIDTH = 16) ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] command_linear;
	logic signed [VALUE_WIDTH-1:0] command_angular;

	modport source(output valid, command_linear, command_angular, input ready);
	modport sink(input valid, command_linear, command_angular, output ready);
endinterface

### rtl/core/vprl_cfg.sv
// Configuration register file of the velocity profile rate limiter.
`timescale 1ns / 1ps

module vprl_cfg #(
	parameter int VALUE_WIDTH = 16,
	localparam int CfgW = (VALUE_WIDTH > vprl_pkg::LIMIT_W) ? VALUE_WIDTH : vprl_pkg::LIMIT_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vprl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [CfgW-1:0]                   cfg_data,
	output logic signed [VALUE_WIDTH-1:0]     speed_floor,
	output logic signed [VALUE_WIDTH-1:0]     speed_ceiling,
	output logic [vprl_pkg::LIMIT_W-1:0]      turn_limit,
	output logic [vprl_pkg::LIMIT_W-1:0]      step_delta_v,
	output logic [vprl_pkg::LIMIT_W-1:0]      step_delta_w
);

	// A ceiling above the value range acts as the range top.
	localparam logic signed [VALUE_WIDTH-1:0] CeilRst = (VALUE_WIDTH > 11) ?
		VALUE_WIDTH'(vprl_pkg::CEILING_RST) : {1'b0, {(VALUE_WIDTH-1){1'b1}}};

	logic signed [VALUE_WIDTH-1:0]  floor_q;
	logic signed [VALUE_WIDTH-1:0]  ceiling_q;
	logic [vprl_pkg::LIMIT_W-1:0]   turn_q;
	logic [vprl_pkg::LIMIT_W-1:0]   dv_q;
	logic [vprl_pkg::LIMIT_W-1:0]   dw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= '0;
			ceiling_q <= CeilRst;
			turn_q    <= vprl_pkg::TURN_LIMIT_RST;
			dv_q      <= vprl_pkg::STEP_DELTA_RST;
			dw_q      <= vprl_pkg::STEP_DELTA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vprl_pkg::CFG_SPEED_FLOOR:   floor_q   <= cfg_data[VALUE_WIDTH-1:0];
				vprl_pkg::CFG_SPEED_CEILING: ceiling_q <= cfg_data[VALUE_WIDTH-1:0];
				vprl_pkg::CFG_TURN_LIMIT:    turn_q    <= cfg_data[vprl_pkg::LIMIT_W-1:0];
				vprl_pkg::CFG_STEP_DELTA_V:  dv_q      <= cfg_data[vprl_pkg::LIMIT_W-1:0];
				vprl_pkg::CFG_STEP_DELTA_W:  dw_q      <= cfg_data[vprl_pkg::LIMIT_W-1:0];
				default: ; // unknown index: drop the write
			endcase
		end
	end

	assign speed_floor   = floor_q;
	assign speed_ceiling = ceiling_q;
	assign turn_limit    = turn_q;
	assign step_delta_v  = dv_q;
	assign step_delta_w  = dw_q;

endmodule

### rtl/core/vprl_ctrl.sv
// Sequencer of the velocity profile rate limiter: load, backward walk, finish.
`timescale 1ns / 1ps

module vprl_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vprl_pkg::ctrl_status_t sts,
	output vprl_pkg::ctrl_cmd_t    ctl
);

	vprl_pkg::ctrl_state_t state_q;
	vprl_pkg::ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vprl_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			vprl_pkg::ST_LOAD: begin
				if (sts.in_valid && sts.in_last) state_nxt = vprl_pkg::ST_WALK;
			end
			vprl_pkg::ST_WALK: begin
				if (!sts.walking) state_nxt = vprl_pkg::ST_FINISH;
			end
			vprl_pkg::ST_FINISH: begin
				if (sts.out_free) state_nxt = vprl_pkg::ST_LOAD;
			end
			default: state_nxt = vprl_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			vprl_pkg::ST_LOAD:   ctl.in_ready = 1'b1;
			vprl_pkg::ST_WALK:   ctl.walk     = 1'b1;
			vprl_pkg::ST_FINISH: ctl.finish   = sts.out_free;
			default:             ctl          = '0;
		endcase
	end

endmodule

### rtl/core/vprl_dp.sv
// Datapath: clamp, forward limit, profile memory, backward walk, command register.
`timescale 1ns / 1ps

module vprl_dp #(
	parameter int HORIZON_MAX = 64,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vprl_pkg::ctrl_cmd_t            ctl,
	output vprl_pkg::ctrl_status_t         sts,
	input  logic                           in_valid,
	input  logic signed [VALUE_WIDTH-1:0]  in_linear,
	input  logic signed [VALUE_WIDTH-1:0]  in_angular,
	input  logic                           in_last,
	input  logic signed [VALUE_WIDTH-1:0]  speed_floor,
	input  logic signed [VALUE_WIDTH-1:0]  speed_ceiling,
	input  logic [vprl_pkg::LIMIT_W-1:0]   turn_limit,
	input  logic [vprl_pkg::LIMIT_W-1:0]   step_delta_v,
	input  logic [vprl_pkg::LIMIT_W-1:0]   step_delta_w,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic signed [VALUE_WIDTH-1:0]  out_linear,
	output logic signed [VALUE_WIDTH-1:0]  out_angular
);

	localparam int VW = VALUE_WIDTH;
	localparam int LW = vprl_pkg::LIMIT_W;
	localparam int EW = ((VW > LW) ? VW : LW) + 2;
	localparam int CW = $clog2(HORIZON_MAX + 1);
	localparam int AW = $clog2(HORIZON_MAX);
	localparam logic signed [EW-1:0] VMax = {{(EW-VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic signed [EW-1:0] VMin = ~VMax;

	function automatic logic signed [EW-1:0] sx(input logic [VW-1:0] v);
		return {{(EW-VW){v[VW-1]}}, v};
	endfunction

	function automatic logic signed [EW-1:0] zx(input logic [LW-1:0] v);
		return {{(EW-LW){1'b0}}, v};
	endfunction

	function automatic logic signed [EW-1:0] sat_f(input logic signed [EW-1:0] x);
		logic signed [EW-1:0] r;
		r = x;
		if (x > VMax) r = VMax;
		if (x < VMin) r = VMin;
		return r;
	endfunction

	// Floor first, then ceiling: a floor above the ceiling yields the ceiling.
	function automatic logic signed [EW-1:0] bound_f(input logic signed [EW-1:0] x,
			input logic signed [EW-1:0] lo, input logic signed [EW-1:0] hi);
		logic signed [EW-1:0] r;
		r = (x < lo) ? lo : x;
		return (r > hi) ? hi : r;
	endfunction

	function automatic logic signed [EW-1:0] near_f(input logic signed [EW-1:0] x,
			input logic signed [EW-1:0] a, input logic signed [EW-1:0] d);
		return bound_f(x, sat_f(a - d), sat_f(a + d));
	endfunction

	logic [2*VW-1:0] prof_mem [HORIZON_MAX];

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          left_q;
	logic                   pend_s1;
	logic                   out_valid_q;
	logic [2*VW-1:0]        rd_s1;
	logic signed [VW-1:0]   prev_lin_q, prev_ang_q;
	logic signed [VW-1:0]   run_lin_q, run_ang_q;
	logic signed [VW-1:0]   out_lin_q, out_ang_q;

	logic                   accept;
	logic                   stored;
	logic                   rd_en;
	logic                   walking;
	logic [CW-1:0]          rd_ptr;
	logic [AW-1:0]          rd_addr;
	logic signed [EW-1:0]   lin_c, ang_c, lin_f, ang_f, tl_x, dv_x, dw_x;
	logic signed [EW-1:0]   lin_b, ang_b;
	logic signed [VW-1:0]   lin_new, ang_new, lin_walk, ang_walk;

	always_comb begin
		accept  = ctl.in_ready & in_valid;
		stored  = count_q < CW'(HORIZON_MAX);
		walking = (left_q != '0) || pend_s1;
		rd_en   = ctl.walk && (left_q != '0);
		rd_ptr  = left_q - CW'(1);
		rd_addr = rd_ptr[AW-1:0];

		tl_x  = zx(turn_limit);
		dv_x  = zx(step_delta_v);
		dw_x  = zx(step_delta_w);
		lin_c = bound_f(sx(in_linear), sx(speed_floor), sx(speed_ceiling));
		ang_c = bound_f(sx(in_angular), -tl_x, tl_x);
		lin_f = (count_q != '0) ? near_f(lin_c, sx(prev_lin_q), dv_x) : lin_c;
		ang_f = (count_q != '0) ? near_f(ang_c, sx(prev_ang_q), dw_x) : ang_c;
		lin_new = lin_f[VW-1:0];
		ang_new = ang_f[VW-1:0];

		// Backward step: earlier stored value against the one that follows it.
		lin_b = near_f(sx(rd_s1[2*VW-1:VW]), sx(run_lin_q), dv_x);
		ang_b = near_f(sx(rd_s1[VW-1:0]), sx(run_ang_q), dw_x);
		lin_walk = lin_b[VW-1:0];
		ang_walk = ang_b[VW-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept && stored) prof_mem[count_q[AW-1:0]] <= {lin_new, ang_new};
		if (rd_en) rd_s1 <= prof_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			left_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && in_last) begin
				count_q <= '0;
				left_q  <= stored ? count_q : count_q - CW'(1);
			end else begin
				if (accept && stored) count_q <= count_q + CW'(1);
				if (rd_en) left_q <= left_q - CW'(1);
			end
			pend_s1 <= rd_en;
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && stored) begin
			prev_lin_q <= lin_new;
			prev_ang_q <= ang_new;
		end
		if (accept && in_last) begin
			run_lin_q <= stored ? lin_new : prev_lin_q;
			run_ang_q <= stored ? ang_new : prev_ang_q;
		end else if (ctl.walk && pend_s1) begin
			run_lin_q <= lin_walk;
			run_ang_q <= ang_walk;
		end
		if (ctl.finish) begin
			out_lin_q <= run_lin_q;
			out_ang_q <= run_ang_q;
		end
	end

	always_comb begin
		sts.in_valid = in_valid;
		sts.in_last  = in_last;
		sts.walking  = walking;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_linear  = out_lin_q;
	assign out_angular = out_ang_q;

	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walking |-> !accept)
		else $error("step accepted during backward walk");

	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (count_q == '0))
		else $error("step count not cleared after final step");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> (!walking && !accept))
		else $error("command loaded while walk still running");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !stored) |-> (count_q == CW'(HORIZON_MAX)))
		else $error("step dropped before horizon full");

endmodule

### rtl/core/velocity_profile_rate_limiter.sv
// Top level of the velocity profile rate limiter.
`timescale 1ns / 1ps

// Velocity profile rate limiter. Feed a horizon of (linear, angular) reference
// velocity beats on step, the final one with last_step set; one command beat
// comes out on cmd per horizon. Each beat is clamped (linear to floor/ceiling,
// with the ceiling winning when the floor lies above it, angular to
// +/- turn_limit), then held within the step delta of the previous stored step
// and written to the profile memory. After the final beat the sequencer walks
// the memory backward, one stored step per cycle through a single registered
// read port, pulling each earlier value within the delta of the one after it,
// and the smoothed first step becomes the command. Step beats are taken only
// while loading, not during the walk or the command load. Steps beyond
// HORIZON_MAX are dropped, yet a dropped final beat still closes the horizon.
// The command sits in an output register, and loading restarts as soon as it
// is written; a second horizon only waits if the earlier command is still
// untaken. Values are signed Q5.10 at the default width; bounds saturate.
// A register write between beats of a horizon applies from the next beat on;
// hold the registers from the final beat until its command is out, since the
// backward walk reads them. Register indexes: floor 0, ceiling 1, turn limit 2,
// linear delta 3, angular delta 4; other indexes are ignored.
module velocity_profile_rate_limiter #(
	parameter int HORIZON_MAX = 64,
	parameter int VALUE_WIDTH = 16,
	localparam int CfgW = (VALUE_WIDTH > vprl_pkg::LIMIT_W) ? VALUE_WIDTH : vprl_pkg::LIMIT_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	vprl_step_if.sink                      step,
	vprl_cmd_if.source                     cmd,
	input  logic                           cfg_we,
	input  logic [vprl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CfgW-1:0]                cfg_data
);

	vprl_pkg::ctrl_cmd_t    ctl;
	vprl_pkg::ctrl_status_t sts;

	logic signed [VALUE_WIDTH-1:0] speed_floor;
	logic signed [VALUE_WIDTH-1:0] speed_ceiling;
	logic [vprl_pkg::LIMIT_W-1:0]  turn_limit;
	logic [vprl_pkg::LIMIT_W-1:0]  step_delta_v;
	logic [vprl_pkg::LIMIT_W-1:0]  step_delta_w;

	// Registers must hold from the final beat until its command is out.
	vprl_cfg #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.speed_floor  (speed_floor),
		.speed_ceiling(speed_ceiling),
		.turn_limit   (turn_limit),
		.step_delta_v (step_delta_v),
		.step_delta_w (step_delta_w)
	);

	// Sequencer: accept beats, run the backward walk, hand off the command.
	vprl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.ctl   (ctl)
	);

	// Datapath owns the profile memory, the step count and the output register.
	vprl_dp #(
		.HORIZON_MAX(HORIZON_MAX),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.in_valid     (step.valid),
		.in_linear    (step.ref_linear),
		.in_angular   (step.ref_angular),
		.in_last      (step.last_step),
		.speed_floor  (speed_floor),
		.speed_ceiling(speed_ceiling),
		.turn_limit   (turn_limit),
		.step_delta_v (step_delta_v),
		.step_delta_w (step_delta_w),
		.out_ready    (cmd.ready),
		.out_valid    (cmd.valid),
		.out_linear   (cmd.command_linear),
		.out_angular  (cmd.command_angular)
	);

	assign step.ready = ctl.in_ready;

endmodule

### verif/velocity_profile_rate_limiter_test.sv
// Self-checking testbench of the velocity profile rate limiter: directed and random horizons.
`timescale 1ns / 1ps

module velocity_profile_rate_limiter_test;

	localparam int HORIZON       = 64;
	localparam int VW            = 16;
	localparam int CFG_W         = (VW > vprl_pkg::LIMIT_W) ? VW : vprl_pkg::LIMIT_W;
	localparam int VEL_MAX       = (1 << (VW - 1)) - 1;
	localparam int VEL_MIN       = -VEL_MAX - 1;
	localparam int LIMIT_MAX     = (1 << vprl_pkg::LIMIT_W) - 1;
	localparam int CFG_INDEX_TOP = (1 << vprl_pkg::CFG_IDX_W) - 1;
	// settle time after a full horizon's final beat: walk and command load, plus margin
	localparam int SETTLE_CYCLES = 2 * HORIZON + 12;
	localparam int STALL_LIMIT   = 3000;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_ITEMS  = 1300;

	typedef struct packed {
		logic signed [VW-1:0] lin;
		logic signed [VW-1:0] ang;
	} command_t;

	// stall patterns of the command receiver
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_COMB
	} rx_pattern_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [vprl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]               cfg_data;

	vprl_step_if #(.VALUE_WIDTH(VW)) step_ch ();
	vprl_cmd_if #(.VALUE_WIDTH(VW)) cmd_ch ();

	velocity_profile_rate_limiter #(
		.HORIZON_MAX(HORIZON),
		.VALUE_WIDTH(VW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.step(step_ch),
		.cmd(cmd_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Register copies as the block holds them, with their reset values.
	int floor_lvl   = 0;
	int ceiling_lvl = 1024;
	int turn_lvl    = 1024;
	int delta_v     = 51;
	int delta_w     = 51;

	// Forward-limited profile of the horizon being loaded.
	int lin_profile[HORIZON];
	int ang_profile[HORIZON];
	int stored_steps = 0;

	// Commands owed by the block, oldest first.
	command_t due_commands[$];

	int errors       = 0;
	int idle_cycles  = 0;
	int burst_left   = 0;
	bit gaps_on      = 1'b1;
	int hold_request = 0;

	always #10 clk = ~clk;

	function automatic int sat_vel(int x);
		return (x > VEL_MAX) ? VEL_MAX : (x < VEL_MIN) ? VEL_MIN : x;
	endfunction

	// Floor first, then ceiling, so a floor above the ceiling yields the ceiling.
	function automatic int clip(int x, int lo, int hi);
		int r;
		r = (x < lo) ? lo : x;
		return (r > hi) ? hi : r;
	endfunction

	function automatic int pull_toward(int x, int anchor, int delta);
		return clip(x, sat_vel(anchor - delta), sat_vel(anchor + delta));
	endfunction

	// Advance the profile by one accepted step beat; close the horizon on the final one.
	function automatic void smooth_step(logic signed [VW-1:0] ref_v, logic signed [VW-1:0] ref_w,
			logic is_last);
		int       v;
		int       w;
		command_t c;
		v = ref_v;
		w = ref_w;
		// steps beyond the horizon depth are dropped without effect
		if (stored_steps < HORIZON) begin
			v = clip(v, floor_lvl, ceiling_lvl);
			w = clip(w, -turn_lvl, turn_lvl);
			// the first step of a horizon is only clamped
			if (stored_steps > 0) begin
				v = pull_toward(v, lin_profile[stored_steps - 1], delta_v);
				w = pull_toward(w, ang_profile[stored_steps - 1], delta_w);
			end
			lin_profile[stored_steps] = v;
			ang_profile[stored_steps] = w;
			stored_steps++;
		end
		if (is_last) begin
			// walk backward, holding each step within the delta of its successor
			for (int i = stored_steps - 1; i > 0; i--) begin
				lin_profile[i - 1] = pull_toward(lin_profile[i - 1], lin_profile[i], delta_v);
				ang_profile[i - 1] = pull_toward(ang_profile[i - 1], ang_profile[i], delta_w);
			end
			c.lin = VW'(lin_profile[0]);
			c.ang = VW'(ang_profile[0]);
			due_commands.push_back(c);
			stored_steps = 0;
		end
	endfunction

	// Check command beats, track step beats, and watch for a hung block.
	always @(posedge clk) begin
		command_t want;
		bit       moved;
		moved = 1'b0;
		// check before tracking, so a command never matches a beat of this very edge
		if (cmd_ch.valid && cmd_ch.ready) begin
			moved = 1'b1;
			if (due_commands.size() == 0) begin
				errors++;
				$display("%0t: command beat with none owed, linear %0d angular %0d", $time,
					cmd_ch.command_linear, cmd_ch.command_angular);
			end else begin
				want = due_commands.pop_front();
				if (cmd_ch.command_linear !== want.lin) begin
					errors++;
					$display("%0t: command_linear expected %0d actual %0d", $time, want.lin,
						cmd_ch.command_linear);
				end
				if (cmd_ch.command_angular !== want.ang) begin
					errors++;
					$display("%0t: command_angular expected %0d actual %0d", $time, want.ang,
						cmd_ch.command_angular);
				end
			end
		end
		if (step_ch.valid && step_ch.ready) begin
			moved = 1'b1;
			smooth_step(step_ch.ref_linear, step_ch.ref_angular, step_ch.last_step);
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Command receiver: switch between stall patterns; honor a long hold-off on request.
	initial begin
		rx_pattern_t pattern;
		int          pattern_left;
		int          hold_left;
		int          tick;
		cmd_ch.ready <= 1'b0;
		pattern = RX_OPEN;
		pattern_left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				cmd_ch.ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern = rx_pattern_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(20, 300);
				end
				pattern_left--;
				case (pattern)
					RX_OPEN: cmd_ch.ready <= 1'b1;
					RX_COIN: cmd_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: cmd_ch.ready <= ($urandom_range(0, 3) == 0);
					default: cmd_ch.ready <= (tick % 5 != 0);
				endcase
			end
		end
	end

	// Write one register and update the register copy to match.
	task automatic write_reg(logic [vprl_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			vprl_pkg::CFG_SPEED_FLOOR: floor_lvl = int'($signed(value[VW-1:0]));
			vprl_pkg::CFG_SPEED_CEILING: ceiling_lvl = int'($signed(value[VW-1:0]));
			vprl_pkg::CFG_TURN_LIMIT: turn_lvl = int'(value[vprl_pkg::LIMIT_W-1:0]);
			vprl_pkg::CFG_STEP_DELTA_V: delta_v = int'(value[vprl_pkg::LIMIT_W-1:0]);
			vprl_pkg::CFG_STEP_DELTA_W: delta_w = int'(value[vprl_pkg::LIMIT_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi, logic [CFG_W-1:0] turn,
			logic [CFG_W-1:0] dv, logic [CFG_W-1:0] dw);
		write_reg(vprl_pkg::CFG_SPEED_FLOOR, lo);
		write_reg(vprl_pkg::CFG_SPEED_CEILING, hi);
		write_reg(vprl_pkg::CFG_TURN_LIMIT, turn);
		write_reg(vprl_pkg::CFG_STEP_DELTA_V, dv);
		write_reg(vprl_pkg::CFG_STEP_DELTA_W, dw);
	endtask

	// Offer one step beat and return at the edge that accepts it, valid still high.
	// Bursts of random length alternate with random gaps.
	task automatic send_step(logic signed [VW-1:0] v, logic signed [VW-1:0] w, logic is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (!gaps_on)
				gap = 0;
			else if ($urandom_range(0, 9) == 0)
				gap = $urandom_range(20, 150);
			else
				gap = $urandom_range(0, 6);
			if (gap > 0) begin
				step_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		step_ch.valid <= 1'b1;
		step_ch.ref_linear <= v;
		step_ch.ref_angular <= w;
		step_ch.last_step <= is_last;
		do @(posedge clk); while (!step_ch.ready);
	endtask

	// Drop valid, wait until every owed command has come, then hold for extra cycles.
	task automatic drain_commands(int extra);
		step_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_commands.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Mostly drift around the previous value; now and then jump to an extreme or anywhere.
	function automatic int next_ref(int prev, int spread);
		case ($urandom_range(0, 19))
			0: return VEL_MIN;
			1: return VEL_MAX;
			2, 3: return int'($signed(VW'($urandom)));
			default: return sat_vel(prev + int'($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	task automatic send_horizon(int len, int spread);
		int lin;
		int ang;
		lin = int'($urandom_range(0, 8000)) - 4000;
		ang = int'($urandom_range(0, 8000)) - 4000;
		for (int k = 0; k < len; k++) begin
			lin = next_ref(lin, spread);
			ang = next_ref(ang, spread);
			send_step(VW'(lin), VW'(ang), k == len - 1);
		end
	endtask

	function automatic logic [CFG_W-1:0] pick_level(int center);
		case ($urandom_range(0, 7))
			0: return CFG_W'(VEL_MIN);
			1: return CFG_W'(VEL_MAX);
			2: return CFG_W'($urandom);
			default: return CFG_W'(center + int'($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	// The top data bit lies beyond the 15-bit limit registers and must be ignored.
	function automatic logic [CFG_W-1:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CFG_W'(LIMIT_MAX);
			2: return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(1, 400));
		endcase
	endfunction

	// Reset register values, clamping to the default ceiling and turn limit.
	task automatic test_reset_defaults();
		send_step(16'sd2000, -16'sd2000, 1'b0);
		send_step(16'sd0, 16'sd0, 1'b0);
		send_step(-16'sd100, 16'sd600, 1'b1);
	endtask

	// Full-range limits: angular clamps to the symmetric bound, bounds saturate.
	task automatic test_field_extremes();
		drain_commands(SETTLE_CYCLES);
		write_all(CFG_W'(VEL_MIN), CFG_W'(VEL_MAX), CFG_W'(LIMIT_MAX), CFG_W'(LIMIT_MAX),
			CFG_W'(LIMIT_MAX));
		send_step(VW'(VEL_MIN), VW'(VEL_MIN), 1'b1);
		send_step(VW'(VEL_MAX), VW'(VEL_MAX), 1'b1);
		send_step(VW'(VEL_MAX), VW'(VEL_MIN), 1'b0);
		send_step(VW'(VEL_MIN), VW'(VEL_MAX), 1'b1);
		drain_commands(SETTLE_CYCLES);
		write_reg(vprl_pkg::CFG_STEP_DELTA_V, CFG_W'(1));
		write_reg(vprl_pkg::CFG_STEP_DELTA_W, '0);
		send_step(VW'(VEL_MAX), VW'(VEL_MAX), 1'b0);
		send_step(VW'(VEL_MIN), VW'(VEL_MIN), 1'b1);
	endtask

	// Floor above ceiling: every linear value lands on the ceiling; zero turn limit.
	task automatic test_floor_above_ceiling();
		drain_commands(SETTLE_CYCLES);
		write_all(CFG_W'(500), CFG_W'(-500), '0, CFG_W'(100), CFG_W'(100));
		send_step(VW'(VEL_MIN), 16'sd1234, 1'b0);
		send_step(VW'(VEL_MAX), -16'sd1, 1'b0);
		send_step(16'sd0, VW'(VEL_MAX), 1'b1);
	endtask

	// Zero deltas pin the whole horizon to its first step.
	task automatic test_zero_delta();
		drain_commands(SETTLE_CYCLES);
		write_all(CFG_W'(-8000), CFG_W'(8000), CFG_W'(8000), '0, '0);
		send_step(16'sd3000, -16'sd3000, 1'b0);
		send_step(-16'sd7000, 16'sd7000, 1'b0);
		send_step(16'sd9000, 16'sd0, 1'b0);
		send_step(16'sd3001, -16'sd2999, 1'b1);
	endtask

	// Change limits between beats of one horizon: later steps and the walk see the new ones.
	task automatic test_mid_horizon_write();
		drain_commands(SETTLE_CYCLES);
		write_all(CFG_W'(-4000), CFG_W'(4000), CFG_W'(4000), CFG_W'(300), CFG_W'(300));
		send_step(16'sd1000, 16'sd1000, 1'b0);
		send_step(16'sd2000, -16'sd2000, 1'b0);
		send_step(-16'sd500, 16'sd3500, 1'b0);
		drain_commands(SETTLE_CYCLES);
		write_reg(vprl_pkg::CFG_TURN_LIMIT, CFG_W'(200));
		write_reg(vprl_pkg::CFG_STEP_DELTA_V, CFG_W'(20));
		send_step(16'sd4000, -16'sd4000, 1'b0);
		send_step(-16'sd4000, 16'sd4000, 1'b1);
	endtask

	// Writes to indexes past the register list must leave every limit alone.
	task automatic test_unused_index();
		drain_commands(SETTLE_CYCLES);
		for (int idx = int'(vprl_pkg::CFG_STEP_DELTA_W) + 1; idx <= CFG_INDEX_TOP; idx++)
			write_reg(vprl_pkg::CFG_IDX_W'(idx), CFG_W'($urandom));
		send_step(16'sd5000, -16'sd5000, 1'b0);
		send_step(-16'sd5000, 16'sd5000, 1'b1);
	endtask

	// A full horizon, then one that overflows so that its final beat is dropped.
	task automatic test_horizon_overflow();
		drain_commands(SETTLE_CYCLES);
		write_all(CFG_W'(-6000), CFG_W'(6000), CFG_W'(6000), CFG_W'(150), CFG_W'(90));
		send_horizon(HORIZON, 500);
		send_horizon(HORIZON + 6, 500);
	endtask

	// Hold the receiver off while beats keep coming, so the block stalls its input.
	task automatic test_output_backpressure();
		drain_commands(0);
		gaps_on = 1'b0;
		hold_request = LONG_HOLD;
		for (int h = 0; h < 6; h++)
			send_horizon($urandom_range(2, 4), 300);
		drain_commands(0);
		gaps_on = 1'b1;
	endtask

	// Phases of random limits, each followed by random horizons, mostly short.
	task automatic test_random_horizons();
		int sent;
		int phase_end;
		int len;
		int pick;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_commands(SETTLE_CYCLES);
			write_all(pick_level(-1500), pick_level(1500), pick_limit(), pick_limit(),
				pick_limit());
			gaps_on = ($urandom_range(0, 3) != 0);
			phase_end = sent + $urandom_range(60, 200);
			while (sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					len = $urandom_range(HORIZON - 4, HORIZON + 8);
				else if (pick < 15)
					len = $urandom_range(9, 30);
				else
					len = $urandom_range(1, 8);
				send_horizon(len, ($urandom_range(0, 3) == 0) ? 30000 : $urandom_range(0, 600));
				sent += len;
				// now and then let the pipe run dry before the next horizon
				if ($urandom_range(0, 15) == 0)
					drain_commands(0);
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		step_ch.valid <= 1'b0;
		step_ch.ref_linear <= '0;
		step_ch.ref_angular <= '0;
		step_ch.last_step <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= vprl_pkg::CFG_SPEED_FLOOR;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_floor_above_ceiling();
		test_zero_delta();
		test_mid_horizon_write();
		test_unused_index();
		test_horizon_overflow();
		test_output_backpressure();
		test_random_horizons();

		drain_commands(SETTLE_CYCLES);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
